// ===== rtl/core/servo_bus_status_packet_receiver_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the servo-bus status packet receiver
// Clocked property checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SERVO_BUS_STATUS_PACKET_RECEIVER_TOP_ASSERT_SVH
`define SERVO_BUS_STATUS_PACKET_RECEIVER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// check outside reset
`define SBSPR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds while reset is applied
`define SBSPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBSPR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SBSPR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/sbspr_pkg.sv =====
// ----------------------------------------------------------------------------
// sbspr_pkg
// Shared types and codes of the servo-bus status packet receiver.
// ----------------------------------------------------------------------------
package sbspr_pkg;

  // action codes of an input request
  localparam logic [2:0] ACT_BYTE  = 3'd0;
  localparam logic [2:0] ACT_TIME  = 3'd1;
  localparam logic [2:0] ACT_POLL  = 3'd2;
  localparam logic [2:0] ACT_REQ   = 3'd3;
  localparam logic [2:0] ACT_TOCHK = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_WAIT    = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD = 3'd1;
  localparam logic [2:0] KIND_CORRUPT = 3'd2;
  localparam logic [2:0] KIND_TIMEOUT = 3'd3;
  localparam logic [2:0] KIND_IN_TIME = 3'd4;

  localparam logic [7:0] SYNC_BYTE     = 8'hff;
  localparam logic [7:0] CHECKSUM_FLAG = 8'h10;
  localparam logic [7:0] MIN_POLL_FILL = 8'd5;
  localparam logic [7:0] FRAME_EXTRA   = 8'd4;
  localparam logic [7:0] MIN_LENGTH    = 8'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
    logic [2:0]  servo_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] payload_byte;
    logic [7:0] servo_error;
    logic       last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       take_byte;   // store rx byte, advance sync logic
    logic       set_time;    // latch now_ms
    logic       clear;       // fill to zero, mark request time
    logic       poll_begin;  // latch id, address 2, clear sum
    logic       addr_load4;  // address 4 (first payload byte)
    logic       step;        // advance buffer address
    logic       sum_en;      // add read byte into checksum
    logic       flag_ok;     // store error byte for the servo
    logic       flag_bad;    // set checksum flag, drop buffer
    logic       emit;        // load result register
    logic [2:0] kind;
    logic       last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic short_buf;  // not enough bytes held yet
    logic at_end;     // read byte is the one before the checksum
    logic pkt_ok;     // length, id and checksum good
    logic expired;    // response time exceeded
  } dp_sts_t;

endpackage

// ===== rtl/core/sbspr_datapath.sv =====
// ----------------------------------------------------------------------------
// sbspr_datapath
// Packet buffer, sync logic, checksum walk, servo flags, timers, result reg.
// ----------------------------------------------------------------------------
`include "servo_bus_status_packet_receiver_top_assert.svh"

module sbspr_datapath #(
  parameter int BUFFER_BYTES = 64,
  parameter int SERVO_COUNT  = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sbspr_pkg::in_item_t in_data,
  input  sbspr_pkg::dp_cmd_t  cmd,
  output sbspr_pkg::dp_sts_t  sts,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [30:0]         cfg_data,
  output logic                out_valid,
  output sbspr_pkg::out_item_t out_data
);
  import sbspr_pkg::*;

  localparam int FW = $clog2(BUFFER_BYTES + 1);
  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = (FW > 9) ? FW + 1 : 10;
  localparam int SW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

  logic [7:0]    mem [BUFFER_BYTES];
  logic [7:0]    rd_data_r;
  logic [FW-1:0] fill_r, fill_nxt, fbase;
  logic [FW-1:0] addr_r;
  logic [7:0]    b1_r, b2_r, b3_r, b4_r;
  logic [7:0]    sum_r;
  logic [2:0]    id_r;
  logic [31:0]   step_time_r, req_time_r, elapsed;
  logic [30:0]   timeout_r;
  logic [7:0]    flags_r [SERVO_COUNT];
  logic          out_valid_r;
  out_item_t     out_data_r, out_nxt;

  logic [2:0]    id_sel;
  logic [3:0]    slot_w;
  logic [SW-1:0] slot;
  logic          has_servo;
  logic [7:0]    cur_err;
  logic [CW-1:0] total_w;
  logic [7:0]    rx;

  assign rx = in_data.rx_byte;

  // servo slot of the polled id
  assign id_sel    = cmd.poll_begin ? in_data.servo_id : id_r;
  assign slot_w    = {1'b0, id_sel} - 4'd2;
  assign slot      = slot_w[SW-1:0];
  assign has_servo = (id_sel >= 3'd2) && (32'(slot_w) < 32'(SERVO_COUNT));
  assign cur_err   = has_servo ? flags_r[slot] : 8'h00;

  // sync / fill logic for a received byte
  always_comb begin
    fbase    = (fill_r >= FW'(BUFFER_BYTES)) ? '0 : fill_r;
    fill_nxt = fbase;
    if (fbase != '0 || rx == SYNC_BYTE) begin
      if (fbase == FW'(2) && rx == SYNC_BYTE) begin
        fill_nxt = (b1_r != SYNC_BYTE) ? FW'(1) : FW'(2);
      end else begin
        fill_nxt = fbase + FW'(1);
      end
    end
  end

  // status
  assign total_w       = CW'(b3_r) + CW'(FRAME_EXTRA);
  assign elapsed       = step_time_r - req_time_r;
  assign sts.short_buf = (CW'(fill_r) < CW'(MIN_POLL_FILL)) || (CW'(fill_r) < total_w);
  assign sts.at_end    = (CW'(addr_r) == total_w - CW'(1));
  assign sts.pkt_ok    = (b3_r >= MIN_LENGTH) && (b2_r == {5'd0, id_r}) &&
                         (rd_data_r == ~sum_r);
  assign sts.expired   = !elapsed[31] && (elapsed[30:0] >= timeout_r);

  // buffer memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      mem[fbase[AW-1:0]] <= rx;
    end
    rd_data_r <= mem[addr_r[AW-1:0]];
  end

  // header shadows and walk registers
  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      if (fbase == FW'(1)) b1_r <= rx;
      if (fbase == FW'(2)) b2_r <= rx;
      if (fbase == FW'(3)) b3_r <= rx;
      if (fbase == FW'(4)) b4_r <= rx;
    end
    if (cmd.poll_begin) begin
      id_r   <= in_data.servo_id;
      addr_r <= FW'(2);
      sum_r  <= 8'h00;
    end else if (cmd.addr_load4) begin
      addr_r <= FW'(4);
    end else if (cmd.step) begin
      addr_r <= addr_r + FW'(1);
    end
    if (cmd.sum_en) begin
      sum_r <= sum_r + rd_data_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      step_time_r <= '0;
      req_time_r  <= '0;
      timeout_r   <= 31'd10;
      for (int i = 0; i < SERVO_COUNT; i++) begin
        flags_r[i] <= 8'h00;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
      if (cmd.set_time) begin
        step_time_r <= in_data.now_ms;
      end
      if (cmd.take_byte) begin
        fill_r <= fill_nxt;
      end else if (cmd.clear) begin
        fill_r     <= '0;
        req_time_r <= step_time_r;
      end else if (cmd.flag_bad) begin
        fill_r <= '0;
      end
      if (has_servo && cmd.flag_ok) begin
        flags_r[slot] <= b4_r;
      end else if (has_servo && cmd.flag_bad) begin
        flags_r[slot] <= flags_r[slot] | CHECKSUM_FLAG;
      end
    end
  end

  // result register
  always_comb begin
    out_nxt              = '0;
    out_nxt.result_kind  = cmd.kind;
    out_nxt.last         = cmd.last;
    case (cmd.kind)
      KIND_WAIT:    out_nxt.servo_error = cur_err;
      KIND_CORRUPT: out_nxt.servo_error = has_servo ? (cur_err | CHECKSUM_FLAG) : 8'h00;
      KIND_PAYLOAD: begin
        out_nxt.payload_byte = rd_data_r;
        out_nxt.servo_error  = has_servo ? b4_r : 8'h00;
      end
      default:      out_nxt.servo_error = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
    if (cmd.emit) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SBSPR_ASSERT(a_fill_bound, clk, rst_n, fill_r <= FW'(BUFFER_BYTES), "fill count past buffer size")
  `SBSPR_ASSERT(a_only_payload_open, clk, rst_n, (out_valid_r && !out_data_r.last) |-> (out_data_r.result_kind == KIND_PAYLOAD), "non-final result is not a payload byte")
  `SBSPR_ASSERT(a_stream_no_gap, clk, rst_n, (out_valid_r && !out_data_r.last) |=> out_valid_r, "gap inside payload stream")
  `SBSPR_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid_r, "result strobe after reset")

endmodule

// ===== rtl/core/sbspr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbspr_ctrl
// Sequencer: decodes requests, walks the checksum and payload stream.
// ----------------------------------------------------------------------------
module sbspr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2:0]         action,
  input  sbspr_pkg::dp_sts_t sts,
  output sbspr_pkg::dp_cmd_t cmd,
  output logic               busy
);
  import sbspr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM_PRIME,
    ST_SUM,
    ST_CHECK,
    ST_STREAM_PRIME,
    ST_STREAM
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.kind  = KIND_WAIT;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (action)
            ACT_BYTE: cmd.take_byte = 1'b1;
            ACT_TIME: cmd.set_time  = 1'b1;
            ACT_REQ:  cmd.clear     = 1'b1;
            ACT_TOCHK: begin
              cmd.emit  = 1'b1;
              cmd.last  = 1'b1;
              cmd.clear = sts.expired;
              cmd.kind  = sts.expired ? KIND_TIMEOUT : KIND_IN_TIME;
            end
            ACT_POLL: begin
              cmd.poll_begin = 1'b1;
              if (sts.short_buf) begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
                cmd.kind = KIND_WAIT;
              end else begin
                state_nxt = ST_SUM_PRIME;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SUM_PRIME: begin
        cmd.step  = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.step   = 1'b1;
        cmd.sum_en = 1'b1;
        if (sts.at_end) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.pkt_ok) begin
          cmd.flag_ok    = 1'b1;
          cmd.addr_load4 = 1'b1;
          state_nxt      = ST_STREAM_PRIME;
        end else begin
          cmd.flag_bad = 1'b1;
          cmd.emit     = 1'b1;
          cmd.last     = 1'b1;
          cmd.kind     = KIND_CORRUPT;
          state_nxt    = ST_IDLE;
        end
      end
      ST_STREAM_PRIME: begin
        cmd.step  = 1'b1;
        state_nxt = ST_STREAM;
      end
      ST_STREAM: begin
        cmd.step = 1'b1;
        cmd.emit = 1'b1;
        cmd.kind = KIND_PAYLOAD;
        cmd.last = sts.at_end;
        if (sts.at_end) begin
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/servo_bus_status_packet_receiver_top.sv =====
// ----------------------------------------------------------------------------
// servo_bus_status_packet_receiver_top
// Status packet receiver for a half-duplex servo bus (protocol 1 framing).
// ----------------------------------------------------------------------------
// Usage:
//  - Input requests: drive in_data and raise start; a request is taken on a
//    clock edge with start high and busy low. Bytes, time updates, request-
//    sent and timeout checks never raise busy.
//  - Results: out_valid strobes for exactly one cycle per result, with
//    out_data holding it; out_data.last marks the final one of a request.
//    The receiver has no back-pressure input and cannot stall.
//  - Answers: a timeout check, or a poll on a short buffer, answers in the
//    cycle after it is taken. A full poll walks the buffer through the single
//    memory read port: first a checksum walk, which ends in a corrupt answer
//    on a bad packet, and for a good packet a second walk that sends the
//    payload bytes one per cycle at the end.
//  - Config: cfg_data (timeout in ms) is written when cfg_valid and
//    cfg_ready are high; cfg_ready is always high. Write only while idle.
//  - Reset (rst_n low, synchronous): fill count, times and servo error
//    flags go to zero, timeout to 10 ms. The buffer contents are not cleared;
//    nothing reads an entry before it is written.
// ----------------------------------------------------------------------------
module servo_bus_status_packet_receiver_top #(
  parameter int BUFFER_BYTES = 64,
  parameter int SERVO_COUNT  = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  start,
  output logic                  busy,
  input  sbspr_pkg::in_item_t   in_data,
  // result channel
  output logic                  out_valid,
  output sbspr_pkg::out_item_t  out_data,
  // config channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [30:0]           cfg_data
);
  import sbspr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // timeout register accepts a write on any cycle
  assign cfg_ready = 1'b1;

  // sequencer: owns busy and all command timing
  sbspr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_data.action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // buffer, checksum, flags, timers and the result register
  sbspr_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .SERVO_COUNT  (SERVO_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
